[hdl/mroq_pkg.sv]
`timescale 1ns / 1ps

package mroq_pkg;

    // Sizes of the queue set
    localparam int NUM_QUEUES  = 4;
    localparam int QUEUE_DEPTH = 64;
    localparam int NUM_READERS = 4;
    localparam int WORD_WIDTH  = 32;

    localparam int Q_BITS     = 2;
    localparam int R_BITS     = 2;
    localparam int SLOT_BITS  = 6;
    localparam int ADDR_BITS  = Q_BITS + SLOT_BITS;
    localparam int SEQ_BITS   = 64;
    localparam int FILL_BITS  = 7;
    localparam int MASK_BITS  = 4;
    localparam int APB_ABITS  = 4;
    localparam int APB_DBITS  = 32;
    localparam int NUM_SLOTS  = NUM_QUEUES * NUM_READERS;

    // Register indexes on the APB port
    localparam logic [1:0] REG_CREATED  = 2'd0;
    localparam logic [1:0] REG_ENABLED  = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    localparam logic [MASK_BITS-1:0] ENABLED_RESET  = 4'hF;
    localparam logic [FILL_BITS-1:0] CAPACITY_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_REGISTER = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_QUEUE  = 3'd1,
        ST_NO_READER = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_NO_SLOT   = 3'd5
    } status_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] created;
        logic [MASK_BITS-1:0] enabled;
        logic [FILL_BITS-1:0] capacity;
    } cfg_t;

    typedef struct packed {
        op_t                   op;
        logic [Q_BITS-1:0]     queue_id;
        logic [R_BITS-1:0]     reader_id;
        logic [WORD_WIDTH-1:0] word;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic                 pop_hit;
        logic [R_BITS-1:0]    granted;
        logic                 lag;
        logic [FILL_BITS-1:0] fill;
    } res_t;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  addr;
        logic [WORD_WIDTH-1:0] wdata;
    } mem_req_t;

endpackage

[hdl/mroq_cfg.sv]
`timescale 1ns / 1ps

module mroq_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mroq_pkg::APB_ABITS-1:0] paddr,
    input  logic [mroq_pkg::APB_DBITS-1:0] pwdata,
    output logic [mroq_pkg::APB_DBITS-1:0] prdata,
    output logic                          pready,
    output mroq_pkg::cfg_t                cfg
);
    import mroq_pkg::*;

    logic [MASK_BITS-1:0] created_reg;
    logic [MASK_BITS-1:0] enabled_reg;
    logic [FILL_BITS-1:0] capacity_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            created_reg  <= '0;
            enabled_reg  <= ENABLED_RESET;
            capacity_reg <= CAPACITY_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_CREATED:  created_reg  <= pwdata[MASK_BITS-1:0];
                REG_ENABLED:  enabled_reg  <= pwdata[MASK_BITS-1:0];
                REG_CAPACITY: capacity_reg <= pwdata[FILL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_CREATED:  prdata = APB_DBITS'(created_reg);
            REG_ENABLED:  prdata = APB_DBITS'(enabled_reg);
            REG_CAPACITY: prdata = APB_DBITS'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.created  = created_reg;
    assign cfg.enabled  = enabled_reg;
    assign cfg.capacity = capacity_reg;

endmodule

[hdl/mroq_entry_ram.sv]
`timescale 1ns / 1ps

module mroq_entry_ram (
    input  logic                             aclk,
    input  mroq_pkg::mem_req_t               mem,
    output logic [mroq_pkg::WORD_WIDTH-1:0]  rd_data
);
    import mroq_pkg::*;

    logic [WORD_WIDTH-1:0] ram [NUM_QUEUES*QUEUE_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    // One port, registered read data held until the next read
    always_ff @(posedge aclk) begin
        if (mem.wr_en) begin
            ram[mem.addr] <= mem.wdata;
        end
        if (mem.rd_en) begin
            rd_data_reg <= ram[mem.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/mroq_queue_state.sv]
`timescale 1ns / 1ps

module mroq_queue_state (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               exec_en,
    input  mroq_pkg::req_t     req,
    input  mroq_pkg::cfg_t     cfg,
    output mroq_pkg::res_t     res,
    output mroq_pkg::mem_req_t mem
);
    import mroq_pkg::*;

    // Per-queue pointers
    logic [SEQ_BITS-1:0]  seq_reg  [NUM_QUEUES];
    logic [FILL_BITS-1:0] fill_reg [NUM_QUEUES];
    logic [SLOT_BITS-1:0] pos_reg  [NUM_QUEUES];
    // Per-reader cursors; an unregistered slot's cursor is never used
    logic [SEQ_BITS-1:0]  cursor_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] regd_reg;

    logic [SEQ_BITS-1:0]  seq_next;
    logic [FILL_BITS-1:0] fill_next;
    logic [SLOT_BITS-1:0] pos_next;
    logic [SEQ_BITS-1:0]  cursor_next;
    logic                 cursor_we;
    logic                 regd_set;

    logic [SEQ_BITS-1:0]    q_seq;
    logic [FILL_BITS-1:0]   q_fill;
    logic [SLOT_BITS-1:0]   q_pos;
    logic                   created;
    logic                   enabled;
    logic [FILL_BITS-1:0]   eff_cap;
    logic [Q_BITS+R_BITS-1:0] ridx;
    logic [Q_BITS+R_BITS-1:0] widx;
    logic [SEQ_BITS-1:0]    cur;
    logic [SEQ_BITS:0]      diff;
    logic                   lag_raw;
    logic [SEQ_BITS-1:0]    offset;
    logic                   off_hi_zero;
    logic [FILL_BITS-1:0]   off_lo;
    logic [SEQ_BITS-1:0]    cur_eff;
    logic [SEQ_BITS-1:0]    cur_inc;
    logic                   free_found;
    logic [R_BITS-1:0]      free_slot;

    assign q_seq   = seq_reg[req.queue_id];
    assign q_fill  = fill_reg[req.queue_id];
    assign q_pos   = pos_reg[req.queue_id];
    assign created = cfg.created[req.queue_id];
    assign enabled = cfg.enabled[req.queue_id];
    assign ridx    = {req.queue_id, req.reader_id};
    assign cur     = cursor_reg[ridx];

    // Capacity clamp: zero acts as one, above the ring depth as the depth
    always_comb begin
        if (cfg.capacity == '0) begin
            eff_cap = FILL_BITS'(1);
        end else if (cfg.capacity > FILL_BITS'(QUEUE_DEPTH)) begin
            eff_cap = FILL_BITS'(QUEUE_DEPTH);
        end else begin
            eff_cap = cfg.capacity;
        end
    end

    // Cursor position relative to the oldest entry; borrow flags a lagging reader
    assign diff        = {1'b0, cur} - {1'b0, q_seq};
    assign lag_raw     = diff[SEQ_BITS];
    assign offset      = lag_raw ? '0 : diff[SEQ_BITS-1:0];
    assign off_hi_zero = (offset[SEQ_BITS-1:FILL_BITS] == '0);
    assign off_lo      = offset[FILL_BITS-1:0];
    assign cur_eff     = lag_raw ? q_seq : cur;
    assign cur_inc     = cur_eff + SEQ_BITS'(1);

    // Lowest free reader slot of the addressed queue
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = NUM_READERS - 1; i >= 0; i--) begin
            if (!regd_reg[{req.queue_id, R_BITS'(i)}]) begin
                free_found = 1'b1;
                free_slot  = R_BITS'(i);
            end
        end
    end

    // Operation decode and next pointer values
    always_comb begin
        seq_next    = q_seq;
        fill_next   = q_fill;
        pos_next    = q_pos;
        cursor_next = cur;
        cursor_we   = 1'b0;
        regd_set    = 1'b0;
        widx        = ridx;
        res.status  = ST_OK;
        res.pop_hit = 1'b0;
        res.granted = '0;
        res.lag     = 1'b0;
        mem.wr_en   = 1'b0;
        mem.rd_en   = 1'b0;
        mem.addr    = {req.queue_id, q_pos + q_fill[SLOT_BITS-1:0]};
        mem.wdata   = req.word;

        unique case (req.op)
            OP_PUSH: begin
                if (!created || !enabled) begin
                    res.status = ST_NO_QUEUE;
                end else begin
                    mem.wr_en = exec_en;
                    if (q_fill >= eff_cap) begin
                        pos_next = q_pos + SLOT_BITS'(1);
                        seq_next = q_seq + SEQ_BITS'(1);
                    end else begin
                        fill_next = q_fill + FILL_BITS'(1);
                    end
                end
            end
            OP_POP: begin
                if (!regd_reg[ridx]) begin
                    res.status = ST_NO_READER;
                end else if (!created) begin
                    res.status = ST_NO_QUEUE;
                end else begin
                    res.lag     = lag_raw;
                    cursor_we   = 1'b1;
                    cursor_next = cur_eff;
                    if (off_hi_zero && (off_lo == q_fill)) begin
                        res.status = ST_EMPTY;
                    end else if (!off_hi_zero || (off_lo > q_fill)) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.pop_hit = 1'b1;
                        mem.rd_en   = exec_en;
                        mem.addr    = {req.queue_id, q_pos + off_lo[SLOT_BITS-1:0]};
                        cursor_next = cur_inc;
                    end
                end
            end
            OP_REGISTER: begin
                if (!created) begin
                    res.status = ST_NO_QUEUE;
                end else if (!free_found) begin
                    res.status = ST_NO_SLOT;
                end else begin
                    res.granted = free_slot;
                    regd_set    = 1'b1;
                    cursor_we   = 1'b1;
                    cursor_next = '0;
                    widx        = {req.queue_id, free_slot};
                end
            end
            OP_CLEAR: begin
                if (!created) begin
                    res.status = ST_NO_QUEUE;
                end else begin
                    fill_next = '0;
                end
            end
            default: ;
        endcase
        res.fill = fill_next;
    end

    // Pointer update on the execute cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                seq_reg[i]  <= '0;
                fill_reg[i] <= '0;
                pos_reg[i]  <= '0;
            end
            regd_reg <= '0;
        end else if (exec_en) begin
            seq_reg[req.queue_id]  <= seq_next;
            fill_reg[req.queue_id] <= fill_next;
            pos_reg[req.queue_id]  <= pos_next;
            if (regd_set) begin
                regd_reg[widx] <= 1'b1;
            end
        end
    end

    // Cursor write
    always_ff @(posedge aclk) begin
        if (exec_en && cursor_we) begin
            cursor_reg[widx] <= cursor_next;
        end
    end

endmodule

[hdl/multi_reader_overwrite_queue.sv]
`timescale 1ns / 1ps

// Channel   Ports                      Contents
// input     s_tvalid/s_tready          s_tuser: opcode; s_tdata: queue, reader, word
// result    m_tvalid/m_tready          m_tdata: status, word, slot, skip flag, fill
// config    psel/penable/pwrite/paddr  created mask, enabled mask, capacity
//
// Each operation runs through an execute cycle that updates the queue
// pointers and issues the entry RAM access, then a response cycle that
// loads the result and the read word into the output register. A new
// transfer is taken when idle or in the response cycle, so one item is
// in flight at a time. Reset is synchronous, active low, and empties all
// queues at once. A stalled result holds the block in its response cycle.
module multi_reader_overwrite_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // queue_id, reader_id, push_word
    input  logic [1:0]                    s_tuser,  // opcode
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // status, pop_word, granted_slot,
                                                    // lag_skipped, fill_level
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mroq_pkg::APB_ABITS-1:0] paddr,
    input  logic [mroq_pkg::APB_DBITS-1:0] pwdata,
    output logic [mroq_pkg::APB_DBITS-1:0] prdata,
    output logic                          pready
);
    import mroq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t                state_reg;
    req_t                  req_reg;
    res_t                  res_reg;
    logic                  m_tvalid_reg;
    logic [47:0]           m_tdata_reg;

    cfg_t                  cfg;
    res_t                  res;
    mem_req_t              mem;
    logic [WORD_WIDTH-1:0] rd_data;
    logic                  out_free;
    logic                  out_load;
    logic                  in_xfer;
    logic                  exec_en;
    logic [WORD_WIDTH-1:0] pop_word;

    mroq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mroq_queue_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (exec_en),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (res),
        .mem     (mem)
    );

    mroq_entry_ram u_ram (
        .aclk    (aclk),
        .mem     (mem),
        .rd_data (rd_data)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == S_RESP) && out_free;
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && out_free);
    assign in_xfer  = s_tvalid && s_tready;
    assign exec_en  = (state_reg == S_EXEC);
    assign pop_word = res_reg.pop_hit ? rd_data : '0;

    // Sequencer, input capture and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Output register: load a finished result, clear after its transfer
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {3'b000, res_reg.fill, res_reg.lag,
                                 res_reg.granted, pop_word, res_reg.status};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (in_xfer) begin
                req_reg.op        <= op_t'(s_tuser);
                req_reg.queue_id  <= s_tdata[1:0];
                req_reg.reader_id <= s_tdata[3:2];
                req_reg.word      <= s_tdata[35:4];
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_reg   <= res;
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        state_reg <= in_xfer ? S_EXEC : S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/mroq_checker.sv]
`timescale 1ns / 1ps

module mroq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import mroq_pkg::*;

    // One item in flight: no transfer in the cycle after one
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on back-to-back cycles");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Data word only on a successful operation
    a_word_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[34:3] == 32'd0))
        else $error("data word with a failing status");

    // Skip flag only on ok, empty or not found
    a_skip_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[37] |->
            (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_EMPTY) ||
            (m_tdata[2:0] == ST_NOT_FOUND))
        else $error("skip flag with a wrong status");

endmodule

bind multi_reader_overwrite_queue mroq_checker u_mroq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import mroq_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles with no transfer before giving up
    localparam int HOLD_CYCLES = 120;   // long receiver hold-off
    localparam int PHASE_ITEMS = 210;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // queue_id[1:0], reader_id[3:2], push_word[35:4], zero pad
    logic [1:0]  s_tuser;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // status[2:0], pop_word[34:3], granted_slot[36:35],
                            // lag_skipped[37], fill_level[44:38], zero pad
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_ABITS-1:0] paddr;
    logic [APB_DBITS-1:0] pwdata;
    logic [APB_DBITS-1:0] prdata;
    logic                 pready;

    bit gaps_on;
    bit hold_request;

    // One reply of the block, unpacked
    typedef struct {
        status_t     status;
        logic [31:0] word;
        logic [1:0]  slot;
        logic        lag;
        logic [6:0]  fill;
    } reply_t;

    // Mirror of the queue set: keeps its own copy of the state and config
    // and the replies still owed by the block.
    class queue_mirror;
        bit [MASK_BITS-1:0] created_mask;
        bit [MASK_BITS-1:0] enabled_mask;
        bit [FILL_BITS-1:0] cap_reg;
        bit [WORD_WIDTH-1:0] store[NUM_QUEUES*QUEUE_DEPTH];
        bit [63:0]           oldest_seq[NUM_QUEUES];
        int unsigned         fill_cnt[NUM_QUEUES];
        int unsigned         oldest_pos[NUM_QUEUES];
        bit [63:0]           cursor[NUM_SLOTS];
        bit                  registered[NUM_SLOTS];
        reply_t              replies_due[$];
        int                  errors;

        function new();
            created_mask = '0;
            enabled_mask = ENABLED_RESET;
            cap_reg = CAPACITY_RESET;
            foreach (store[i]) store[i] = '0;
            foreach (oldest_seq[i]) begin
                oldest_seq[i] = '0;
                fill_cnt[i] = 0;
                oldest_pos[i] = 0;
            end
            foreach (cursor[i]) begin
                cursor[i] = '0;
                registered[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_CREATED:  created_mask = value[MASK_BITS-1:0];
                REG_ENABLED:  enabled_mask = value[MASK_BITS-1:0];
                REG_CAPACITY: cap_reg = value[FILL_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_CREATED:  return 32'(created_mask);
                REG_ENABLED:  return 32'(enabled_mask);
                REG_CAPACITY: return 32'(cap_reg);
                default:      return '0;
            endcase
        endfunction

        // Work out the reply to one accepted operation and update the mirror
        function void apply_op(op_t op, logic [1:0] qid, logic [1:0] rid, logic [31:0] w);
            reply_t      rep;
            int unsigned base;
            int unsigned rslot;
            int unsigned slot;
            int unsigned cap;
            bit [63:0]   offset;
            bit          created;
            rep.status = ST_OK;
            rep.word = '0;
            rep.slot = '0;
            rep.lag = 1'b0;
            base = qid * QUEUE_DEPTH;
            rslot = qid * NUM_READERS + rid;
            created = created_mask[qid];
            cap = (cap_reg == 0) ? 1 : ((cap_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : cap_reg);
            case (op)
                OP_PUSH: begin
                    if (!created || !enabled_mask[qid]) begin
                        rep.status = ST_NO_QUEUE;
                    end else begin
                        slot = (oldest_pos[qid] + fill_cnt[qid]) % QUEUE_DEPTH;
                        store[base + slot] = w;
                        // full: overwrite the oldest entry
                        if (fill_cnt[qid] >= cap) begin
                            oldest_pos[qid] = (oldest_pos[qid] + 1) % QUEUE_DEPTH;
                            oldest_seq[qid] += 64'd1;
                        end else begin
                            fill_cnt[qid] += 1;
                        end
                    end
                end
                OP_POP: begin
                    if (!registered[rslot]) begin
                        rep.status = ST_NO_READER;
                    end else if (!created) begin
                        rep.status = ST_NO_QUEUE;
                    end else begin
                        // reader fell behind: snap it to the oldest entry
                        if (cursor[rslot] < oldest_seq[qid]) begin
                            cursor[rslot] = oldest_seq[qid];
                            rep.lag = 1'b1;
                        end
                        offset = cursor[rslot] - oldest_seq[qid];
                        if (offset == 64'(fill_cnt[qid])) begin
                            rep.status = ST_EMPTY;
                        end else if (offset > 64'(fill_cnt[qid])) begin
                            rep.status = ST_NOT_FOUND;
                        end else begin
                            slot = (oldest_pos[qid] + int'(offset)) % QUEUE_DEPTH;
                            rep.word = store[base + slot];
                            cursor[rslot] += 64'd1;
                        end
                    end
                end
                OP_REGISTER: begin
                    if (!created) begin
                        rep.status = ST_NO_QUEUE;
                    end else begin
                        rep.status = ST_NO_SLOT;
                        for (int i = 0; i < NUM_READERS; i++) begin
                            if (!registered[qid*NUM_READERS + i]) begin
                                registered[qid*NUM_READERS + i] = 1'b1;
                                cursor[qid*NUM_READERS + i] = '0;
                                rep.slot = 2'(i);
                                rep.status = ST_OK;
                                break;
                            end
                        end
                    end
                end
                default: begin
                    if (!created) rep.status = ST_NO_QUEUE;
                    else fill_cnt[qid] = 0;
                end
            endcase
            rep.fill = 7'(fill_cnt[qid]);
            replies_due.push_back(rep);
        endfunction

        // Compare one reply from the block with the oldest one owed
        function void check_reply(logic [47:0] d);
            reply_t want;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply %h", $time, d);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (d[2:0] !== want.status) begin
                $display("%0t: status expected %0d got %0d", $time, want.status, d[2:0]);
                errors++;
            end
            if (d[34:3] !== want.word) begin
                $display("%0t: pop_word expected %h got %h", $time, want.word, d[34:3]);
                errors++;
            end
            if (d[36:35] !== want.slot) begin
                $display("%0t: granted_slot expected %0d got %0d", $time, want.slot,
                         d[36:35]);
                errors++;
            end
            if (d[37] !== want.lag) begin
                $display("%0t: lag_skipped expected %0d got %0d", $time, want.lag, d[37]);
                errors++;
            end
            if (d[44:38] !== want.fill) begin
                $display("%0t: fill_level expected %0d got %0d", $time, want.fill,
                         d[44:38]);
                errors++;
            end
        endfunction
    endclass

    queue_mirror mirror = new();

    multi_reader_overwrite_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Send one operation and wait for its transfer; may idle afterwards
    task automatic send_op(input op_t op, input logic [1:0] qid, input logic [1:0] rid,
                           input logic [31:0] w);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, w, rid, qid};
        do @(posedge aclk); while (s_tready !== 1'b1);
        mirror.apply_op(op, qid, rid, w);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every owed reply, plus the pipeline depth
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (mirror.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One APB access: setup cycle, access cycle, then an idle cycle
    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [31:0] wval, output logic [31:0] rval);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wval;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rval = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Write a register with junk in the unused upper bits, then read it back
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] junk;
        logic [31:0] rd;
        junk = $urandom();
        if (idx == REG_CAPACITY) junk = (junk & ~32'h7F) | (value & 32'h7F);
        else junk = (junk & ~32'hF) | (value & 32'hF);
        apb_access(idx, 1'b1, junk, rd);
        mirror.set_reg(idx, junk);
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== mirror.reg_value(idx)) begin
            $display("%0t: register %0d expected %h got %h", $time, idx,
                     mirror.reg_value(idx), rd);
            mirror.errors++;
        end
    endtask

    task automatic program_queues(input logic [3:0] created, input logic [3:0] enabled,
                                  input logic [6:0] cap);
        wait_drained();
        set_reg(REG_CREATED, 32'(created));
        set_reg(REG_ENABLED, 32'(enabled));
        set_reg(REG_CAPACITY, 32'(cap));
    endtask

    // Random mix: mostly pushes and pops, a few registers and clears
    task automatic run_random(input int n, input bit pause_mid);
        int   roll;
        op_t  op;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) wait_drained();
            roll = $urandom_range(0, 99);
            if (roll < 40) op = OP_PUSH;
            else if (roll < 92) op = OP_POP;
            else if (roll < 95) op = OP_REGISTER;
            else op = OP_CLEAR;
            send_op(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom());
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (gaps_on && aresetn && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    // Reply checking and watchdog
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) mirror.check_reply(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        gaps_on = 1'b1;
        hold_request = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Nothing created yet: every operation is refused
        send_op(OP_PUSH, 2'd0, 2'd0, 32'h1234_5678);
        send_op(OP_POP, 2'd0, 2'd0, 32'h0);
        send_op(OP_REGISTER, 2'd0, 2'd0, 32'h0);
        send_op(OP_CLEAR, 2'd0, 2'd0, 32'h0);

        // All created, queue 0 disabled, two-entry capacity
        program_queues(4'hF, 4'hE, 7'd2);
        send_op(OP_PUSH, 2'd0, 2'd0, 32'hDEAD_BEEF);
        repeat (4) send_op(OP_REGISTER, 2'd0, 2'd3, 32'h0);
        send_op(OP_REGISTER, 2'd0, 2'd0, 32'h0);          // all slots taken
        send_op(OP_PUSH, 2'd1, 2'd0, 32'h0000_0000);
        send_op(OP_PUSH, 2'd1, 2'd0, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 2'd1, 2'd0, 32'hA5A5_5A5A);      // overwrites oldest
        send_op(OP_REGISTER, 2'd1, 2'd0, 32'h0);
        send_op(OP_POP, 2'd1, 2'd0, 32'h0);               // lagging reader
        send_op(OP_POP, 2'd1, 2'd0, 32'h0);
        send_op(OP_POP, 2'd1, 2'd0, 32'h0);               // caught up
        send_op(OP_POP, 2'd1, 2'd1, 32'h0);               // unregistered slot
        send_op(OP_CLEAR, 2'd1, 2'd0, 32'h0);
        send_op(OP_POP, 2'd1, 2'd0, 32'h0);               // cursor past the fill
        send_op(OP_POP, 2'd0, 2'd3, 32'h0);
        send_op(OP_REGISTER, 2'd2, 2'd0, 32'h0);
        send_op(OP_REGISTER, 2'd3, 2'd0, 32'h0);
        send_op(OP_PUSH, 2'd3, 2'd2, $urandom());
        send_op(OP_POP, 2'd3, 2'd0, 32'h0);

        // Queue 1 removed: registered reader still sees a missing queue
        program_queues(4'h5, 4'hF, 7'd64);
        send_op(OP_POP, 2'd1, 2'd0, 32'h0);
        send_op(OP_CLEAR, 2'd1, 2'd0, 32'h0);
        send_op(OP_REGISTER, 2'd1, 2'd0, 32'h0);

        // Random phases over several register settings
        program_queues(4'hF, 4'hF, 7'd64);
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'hF, 4'hF, 7'd1);
        hold_request = 1'b1;
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'hF, 4'h5, 7'd4);
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'h3, 4'hF, 7'd0);
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'hF, 4'hF, 7'd127);
        run_random(PHASE_ITEMS, 1'b1);
        program_queues(4'hF, 4'hA, 7'd3);               // below the current fills
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'hF, 4'h0, 7'd16);
        run_random(PHASE_ITEMS, 1'b0);
        program_queues(4'hF, 4'hF, 7'd64);
        gaps_on = 1'b0;
        run_random(PHASE_ITEMS, 1'b0);

        // Drain and report
        wait_drained();
        repeat (10) @(posedge aclk);
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
